>>> rtl/rbp_pkg.sv
package rbp_pkg;

	// Fixed widths of the datapath
	localparam int unsigned CoordW = 32;  // coordinate field
	localparam int unsigned RegW   = 31;  // configuration register
	localparam int unsigned BaseW  = 33;  // clamp or face point before push-out
	localparam int unsigned MagW   = 30;  // offset magnitude after normalising shift
	localparam int unsigned NumW   = 61;  // offset magnitude times radius
	localparam int unsigned RadW   = 62;  // sum of squared offsets
	localparam int unsigned RootW  = 31;  // integer square root of RadW bits
	localparam int unsigned QuoW   = 31;  // push-out distance per axis

	// Register indexes
	typedef enum logic [1:0] {
		REG_HALF_X = 2'd0,
		REG_HALF_Y = 2'd1,
		REG_HALF_Z = 2'd2,
		REG_RADIUS = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [CoordW-1:0] pos_x;
		logic signed [CoordW-1:0] pos_y;
		logic signed [CoordW-1:0] pos_z;
	} in_t;

	typedef struct packed {
		logic signed [CoordW-1:0] proj_x;
		logic signed [CoordW-1:0] proj_y;
		logic signed [CoordW-1:0] proj_z;
		logic                     is_inside;
	} out_t;

	// Box geometry as seen by the datapath
	typedef struct packed {
		logic [2:0][RegW-1:0] half_len;
		logic [RegW-1:0]      radius;
	} cfg_t;

	// Per-item data that rides alongside the root and divide pipes
	typedef struct packed {
		logic [2:0][NumW-1:0]  num;
		logic [2:0]            neg;
		logic [2:0][BaseW-1:0] base;
		logic                  inner;
		logic                  in_box;
	} side_t;

endpackage

>>> rtl/rbp_front.sv
module rbp_front #(
	parameter int DIMENSIONS = 3
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  rbp_pkg::in_t                in_data,
	input  rbp_pkg::cfg_t               cfg,
	output logic                        out_valid,
	output logic [rbp_pkg::RadW-1:0]    out_sum,
	output rbp_pkg::side_t              out_side
);

	localparam logic [2:0] ACT = (DIMENSIONS >= 3) ? 3'b111 : 3'b011;

	logic signed [31:0] w_in [3];

	assign w_in[0] = in_data.pos_x;
	assign w_in[1] = in_data.pos_y;
	assign w_in[2] = in_data.pos_z;

	// ---------------- stage 1: magnitude, clamp, inside terms
	logic signed [32:0] p_c [3];
	logic signed [32:0] t_c [3];
	logic [31:0]        e_c [3];
	logic               outside_c, inner_c;

	always_comb begin
		logic signed [32:0] wx, aw, len_s, r_s, hi, lo;
		logic [33:0]        e34;
		outside_c = 1'b0;
		inner_c   = 1'b1;
		for (int d = 0; d < 3; d++) begin
			wx    = {w_in[d][31], w_in[d]};
			aw    = w_in[d][31] ? -wx : wx;
			len_s = $signed({2'b00, cfg.half_len[d]});
			r_s   = $signed({2'b00, cfg.radius});
			hi    = len_s - r_s;
			lo    = r_s - len_s;
			e34   = {1'b0, aw} + {3'b000, cfg.radius} - {3'b000, cfg.half_len[d]};
			t_c[d] = len_s - aw;
			p_c[d] = wx;
			e_c[d] = '0;
			if (ACT[d]) begin
				if (aw > len_s) outside_c = 1'b1;
				if (!e34[33] && e34 != '0) e_c[d] = e34[31:0];
				if (p_c[d] > hi) begin
					p_c[d]  = hi;
					inner_c = 1'b0;
				end
				if (p_c[d] < lo) begin
					p_c[d]  = lo;
					inner_c = 1'b0;
				end
			end
		end
	end

	logic               v_s1;
	logic signed [31:0] w_s1 [3];
	logic signed [32:0] p_s1 [3];
	logic signed [32:0] t_s1 [3];
	logic [31:0]        e_s1 [3];
	logic               outside_s1, inner_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int d = 0; d < 3; d++) begin
				w_s1[d] <= w_in[d];
				p_s1[d] <= p_c[d];
				t_s1[d] <= t_c[d];
				e_s1[d] <= e_c[d];
			end
			outside_s1 <= outside_c;
			inner_s1   <= inner_c;
		end
	end

	// ---------------- stage 2: offsets, squares of inside terms, nearest face
	logic [32:0]                  mag_c [3];
	logic [2:0]                   neg_c;
	logic [2:0][rbp_pkg::BaseW-1:0] base_c;

	always_comb begin
		logic signed [33:0] o;
		logic signed [32:0] t_min;
		logic [1:0]         best;
		best  = 2'd0;
		t_min = t_s1[0];
		for (int d = 1; d < 3; d++) begin
			if (ACT[d] && t_s1[d] < t_min) begin
				best  = 2'(d);
				t_min = t_s1[d];
			end
		end
		for (int d = 0; d < 3; d++) begin
			o         = $signed({{2{w_s1[d][31]}}, w_s1[d]}) - $signed({p_s1[d][32], p_s1[d]});
			neg_c[d]  = o[33];
			mag_c[d]  = o[33] ? 33'(-o) : o[32:0];
			base_c[d] = p_s1[d];
			if (inner_s1 && best == 2'(d)) begin
				base_c[d] = (w_s1[d] > 0) ? {2'b00, cfg.half_len[d]}
					: 33'(-$signed({2'b00, cfg.half_len[d]}));
			end
		end
	end

	logic                          v_s2;
	logic [63:0]                   sqe_s2 [3];
	logic [61:0]                   rr_s2;
	logic [32:0]                   mag_s2 [3];
	logic [2:0]                    neg_s2;
	logic [2:0][rbp_pkg::BaseW-1:0] base_s2;
	logic                          outside_s2, inner_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int d = 0; d < 3; d++) begin
				sqe_s2[d] <= 64'(e_s1[d]) * 64'(e_s1[d]);
				mag_s2[d] <= mag_c[d];
			end
			rr_s2      <= 62'(cfg.radius) * 62'(cfg.radius);
			neg_s2     <= neg_c;
			base_s2    <= base_c;
			outside_s2 <= outside_s1;
			inner_s2   <= inner_s1;
		end
	end

	// ---------------- stage 3: normalising shift, inside decision
	logic [rbp_pkg::MagW-1:0] m_c [3];
	logic                     inside_c;

	always_comb begin
		logic [32:0] big;
		logic [1:0]  sh;
		logic [65:0] esum;
		big = mag_s2[0];
		for (int d = 1; d < 3; d++)
			if (mag_s2[d] > big) big = mag_s2[d];
		if (big[32])      sh = 2'd3;
		else if (big[31]) sh = 2'd2;
		else if (big[30]) sh = 2'd1;
		else              sh = 2'd0;
		for (int d = 0; d < 3; d++)
			m_c[d] = rbp_pkg::MagW'(mag_s2[d] >> sh);
		esum     = 66'(sqe_s2[0]) + 66'(sqe_s2[1]) + 66'(sqe_s2[2]);
		inside_c = !outside_s2 && (esum <= 66'(rr_s2));
	end

	logic                          v_s3;
	logic [rbp_pkg::MagW-1:0]      m_s3 [3];
	logic [2:0]                    neg_s3;
	logic [2:0][rbp_pkg::BaseW-1:0] base_s3;
	logic                          inner_s3, inside_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int d = 0; d < 3; d++) m_s3[d] <= m_c[d];
			neg_s3    <= neg_s2;
			base_s3   <= base_s2;
			inner_s3  <= inner_s2;
			inside_s3 <= inside_c;
		end
	end

	// ---------------- stage 4: squared offsets and offset times radius
	logic                 v_s4;
	logic [59:0]          sq_s4 [3];
	rbp_pkg::side_t       side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int d = 0; d < 3; d++) begin
				sq_s4[d]       <= 60'(m_s3[d]) * 60'(m_s3[d]);
				side_s4.num[d] <= rbp_pkg::NumW'(m_s3[d]) * rbp_pkg::NumW'(cfg.radius);
			end
			side_s4.neg    <= neg_s3;
			side_s4.base   <= base_s3;
			side_s4.inner  <= inner_s3;
			side_s4.in_box <= inside_s3;
		end
	end

	// ---------------- stage 5: radicand
	logic                     v_s5;
	logic [rbp_pkg::RadW-1:0] sum_s5;
	rbp_pkg::side_t           side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s5  <= rbp_pkg::RadW'(sq_s4[0]) + rbp_pkg::RadW'(sq_s4[1])
				+ rbp_pkg::RadW'(sq_s4[2]);
			side_s5 <= side_s4;
		end
	end

	assign out_valid = v_s5;
	assign out_sum   = sum_s5;
	assign out_side  = side_s5;

endmodule

>>> rtl/rbp_sqrt.sv
module rbp_sqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [rbp_pkg::RadW-1:0]  in_sum,
	input  rbp_pkg::side_t            in_side,
	output logic                      out_valid,
	output logic [rbp_pkg::RootW-1:0] out_root,
	output rbp_pkg::side_t            out_side
);

	// One result bit per stage, most significant first
	localparam int K = rbp_pkg::RootW;
	localparam int W = rbp_pkg::RadW;

	logic           v_s    [K];
	logic [W-1:0]   rem_s  [K];
	logic [W-1:0]   root_s [K];
	rbp_pkg::side_t side_s [K];

	for (genvar k = 0; k < K; k++) begin : g_step
		localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * k);
		logic           v_i;
		logic [W-1:0]   rem_i, root_i, rem_n, root_n;
		logic [W:0]     trial;
		rbp_pkg::side_t side_i;

		if (k == 0) begin : g_first
			assign v_i    = in_valid;
			assign rem_i  = in_sum;
			assign root_i = '0;
			assign side_i = in_side;
		end else begin : g_next
			assign v_i    = v_s[k-1];
			assign rem_i  = rem_s[k-1];
			assign root_i = root_s[k-1];
			assign side_i = side_s[k-1];
		end

		// trial subtract of root plus current bit
		always_comb begin
			trial = {1'b0, root_i} + {1'b0, BIT};
			if ({1'b0, rem_i} >= trial) begin
				rem_n  = rem_i - trial[W-1:0];
				root_n = (root_i >> 1) + BIT;
			end else begin
				rem_n  = rem_i;
				root_n = root_i >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[k] <= 1'b0;
			else if (en) v_s[k] <= v_i;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= rem_n;
				root_s[k] <= root_n;
				side_s[k] <= side_i;
			end
		end
	end

	assign out_valid = v_s[K-1];
	assign out_root  = root_s[K-1][K-1:0];
	assign out_side  = side_s[K-1];

endmodule

>>> rtl/rbp_div.sv
module rbp_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_valid,
	input  logic [rbp_pkg::RootW-1:0]            in_len,
	input  rbp_pkg::side_t                       in_side,
	output logic                                 out_valid,
	output logic [rbp_pkg::RootW-1:0]            out_len,
	output logic [2:0][rbp_pkg::QuoW-1:0]        out_quo,
	output rbp_pkg::side_t                       out_side
);

	// Restoring division, one quotient bit per stage, three axes abreast
	localparam int K = rbp_pkg::QuoW;
	localparam int N = rbp_pkg::NumW;

	logic                        v_s    [K];
	logic [2:0][N-1:0]           rem_s  [K];
	logic [2:0][K-1:0]           quo_s  [K];
	logic [rbp_pkg::RootW-1:0]   len_s  [K];
	rbp_pkg::side_t              side_s [K];

	for (genvar k = 0; k < K; k++) begin : g_step
		localparam int SH = K - 1 - k;
		logic                      v_i;
		logic [2:0][N-1:0]         rem_i, rem_n;
		logic [2:0][K-1:0]         quo_i, quo_n;
		logic [rbp_pkg::RootW-1:0] len_i;
		logic [N-1:0]              trial;
		rbp_pkg::side_t            side_i;

		if (k == 0) begin : g_first
			assign v_i    = in_valid;
			assign rem_i  = in_side.num;
			assign quo_i  = '0;
			assign len_i  = in_len;
			assign side_i = in_side;
		end else begin : g_next
			assign v_i    = v_s[k-1];
			assign rem_i  = rem_s[k-1];
			assign quo_i  = quo_s[k-1];
			assign len_i  = len_s[k-1];
			assign side_i = side_s[k-1];
		end

		always_comb begin
			trial = N'(len_i) << SH;
			rem_n = rem_i;
			quo_n = quo_i;
			for (int a = 0; a < 3; a++) begin
				if (rem_i[a] >= trial) begin
					rem_n[a]     = rem_i[a] - trial;
					quo_n[a][SH] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[k] <= 1'b0;
			else if (en) v_s[k] <= v_i;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= rem_n;
				quo_s[k]  <= quo_n;
				len_s[k]  <= len_i;
				side_s[k] <= side_i;
			end
		end
	end

	assign out_valid = v_s[K-1];
	assign out_len   = len_s[K-1];
	assign out_quo   = quo_s[K-1];
	assign out_side  = side_s[K-1];

endmodule

>>> rtl/rounded_box_point_projection.sv
// 68 register stages in all: 5 front stages, a 31-stage square-root pipe,
// a 31-stage divider pipe (all three axes in parallel) and an output register.
// Throughput: one item per cycle while the output is not stalled.
// The whole pipe advances together and holds while a result waits on the output.
// Reset clears every valid bit and loads the box registers with 1.0 half extents
// and a 0.25 corner radius.
module rounded_box_point_projection #(
	parameter int DIMENSIONS = 3
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  rbp_pkg::in_t               in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output rbp_pkg::out_t              out_data,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_idx,
	input  logic [rbp_pkg::RegW-1:0]   cfg_data
);

	localparam logic [2:0] ACT = (DIMENSIONS >= 3) ? 3'b111 : 3'b011;

	// ---------------- box registers
	logic [rbp_pkg::RegW-1:0] half_x_q, half_y_q, half_z_q, radius_q;
	rbp_pkg::cfg_t            cfg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_x_q <= 31'd65536;
			half_y_q <= 31'd65536;
			half_z_q <= 31'd65536;
			radius_q <= 31'd16384;
		end else if (cfg_we) begin
			unique case (rbp_pkg::reg_idx_t'(cfg_idx))
				rbp_pkg::REG_HALF_X: half_x_q <= cfg_data;
				rbp_pkg::REG_HALF_Y: half_y_q <= cfg_data;
				rbp_pkg::REG_HALF_Z: half_z_q <= cfg_data;
				rbp_pkg::REG_RADIUS: radius_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.half_len[0] = half_x_q;
	assign cfg.half_len[1] = half_y_q;
	assign cfg.half_len[2] = half_z_q;
	assign cfg.radius      = radius_q;

	// ---------------- pipe enable
	logic out_valid_q;
	logic en;

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	// ---------------- datapath
	logic                         front_valid;
	logic [rbp_pkg::RadW-1:0]     front_sum;
	rbp_pkg::side_t               front_side;
	logic                         root_valid;
	logic [rbp_pkg::RootW-1:0]    root_len;
	rbp_pkg::side_t               root_side;
	logic                         div_valid;
	logic [rbp_pkg::RootW-1:0]    div_len;
	logic [2:0][rbp_pkg::QuoW-1:0] div_quo;
	rbp_pkg::side_t               div_side;

	rbp_front #(.DIMENSIONS(DIMENSIONS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.cfg       (cfg),
		.out_valid (front_valid),
		.out_sum   (front_sum),
		.out_side  (front_side)
	);

	rbp_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (front_valid),
		.in_sum    (front_sum),
		.in_side   (front_side),
		.out_valid (root_valid),
		.out_root  (root_len),
		.out_side  (root_side)
	);

	rbp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (root_valid),
		.in_len    (root_len),
		.in_side   (root_side),
		.out_valid (div_valid),
		.out_len   (div_len),
		.out_quo   (div_quo),
		.out_side  (div_side)
	);

	// ---------------- push-out, saturation, result assembly
	logic signed [31:0] proj_c [3];

	always_comb begin
		logic signed [33:0] base34, delta34, sum34;
		for (int d = 0; d < 3; d++) begin
			base34  = $signed({div_side.base[d][32], div_side.base[d]});
			delta34 = $signed({3'b000, div_quo[d]});
			sum34   = div_side.neg[d] ? base34 - delta34 : base34 + delta34;
			if (!ACT[d]) begin
				proj_c[d] = '0;
			end else if (div_side.inner || div_len == '0) begin
				proj_c[d] = base34[31:0];
			end else if (sum34 > 34'sh0_7FFF_FFFF) begin
				proj_c[d] = 32'sh7FFF_FFFF;
			end else if (sum34 < -34'sh0_8000_0000) begin
				proj_c[d] = 32'sh8000_0000;
			end else begin
				proj_c[d] = sum34[31:0];
			end
		end
	end

	// ---------------- output register
	rbp_pkg::out_t out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= div_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q.proj_x    <= proj_c[0];
			out_data_q.proj_y    <= proj_c[1];
			out_data_q.proj_z    <= proj_c[2];
			out_data_q.is_inside <= div_side.in_box;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTHESIS
	// a waiting result stays put until it is taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while waiting");

	// a point inside the shrunk box is inside the rounded box
	a_inner_inside: assert property (@(posedge clk) disable iff (!arst_n)
		div_valid && div_side.inner |-> div_side.in_box)
		else $error("inner point flagged outside");

	// a stalled pipe holds its tail
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(div_valid) && $stable(div_len) && $stable(div_quo))
		else $error("pipe moved during stall");
`endif

endmodule
